>>> rtl/ipv4rx_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 receive header check package
// Types, status codes and header constants shared by the parse, verdict and
// top-level modules.
// ----------------------------------------------------------------------------
package ipv4rx_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [0:0] REG_TCP_CONN_OPEN = 1'b0;

    localparam logic [15:0] HDR_BYTES    = 16'd20;
    localparam logic [15:0] TCP_MIN_HDR  = 16'd20;
    localparam logic [15:0] BYTE_CNT_MAX = 16'hFFFF;
    localparam logic [15:0] SUM_ONES     = 16'hFFFF;

    localparam logic [15:0] POS_VER_IHL   = 16'd0;
    localparam logic [15:0] POS_TLEN_HI   = 16'd2;
    localparam logic [15:0] POS_TLEN_LO   = 16'd3;
    localparam logic [15:0] POS_PROTO     = 16'd9;
    localparam logic [15:0] POS_SRC_FIRST = 16'd12;
    localparam logic [15:0] POS_SRC_LAST  = 16'd15;
    localparam logic [15:0] POS_TCP_OFF   = 16'd32;

    localparam logic [3:0] IP_VERSION = 4'd4;
    localparam logic [3:0] IP_IHL     = 4'd5;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;

    typedef enum logic [3:0] {
        ST_SHORT        = 4'd0,
        ST_VERSION      = 4'd1,
        ST_IHL          = 4'd2,
        ST_LENGTH       = 4'd3,
        ST_CHECKSUM     = 4'd4,
        ST_ICMP         = 4'd5,
        ST_TCP          = 4'd6,
        ST_TCP_NO_CONN  = 4'd7,
        ST_TCP_BAD_HDR  = 4'd8,
        ST_OTHER        = 4'd9
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        t_status     status;
        logic [7:0]  protocol_num;
        logic [31:0] source_addr;
        logic [15:0] payload_length;
        logic [5:0]  tcp_header_length;
        logic [15:0] tcp_payload_length;
    } t_out_beat;

    typedef struct packed {
        logic [15:0] byte_count;
        logic [16:0] sum;
        logic [7:0]  ver_ihl;
        logic [15:0] total_length;
        logic [15:0] payload_length;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [3:0]  tcp_offset;
    } t_hdr_snap;

endpackage

>>> rtl/ipv4rx_parse.sv
// ----------------------------------------------------------------------------
// IPv4 receive header parser
// Counts packet bytes, accumulates the header checksum and captures header
// fields; on the last byte it hands a snapshot to the verdict stage.
// ----------------------------------------------------------------------------
module ipv4rx_parse (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  ipv4rx_pkg::t_in_beat  i_in_beat,
    output logic                  o_in_ready,
    input  logic                  i_snap_take,
    output logic                  o_snap_vld,
    output ipv4rx_pkg::t_hdr_snap o_snap
);

    logic [15:0] r_byte_index, n_byte_index;
    logic [16:0] r_sum, n_sum;
    logic [7:0]  r_high_half, n_high_half;
    logic [7:0]  r_ver_ihl, n_ver_ihl;
    logic [15:0] r_total_length, n_total_length;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_src, n_src;
    logic [3:0]  r_tcp_offset, n_tcp_offset;
    logic        r_snap_vld;
    ipv4rx_pkg::t_hdr_snap r_snap;
    logic [17:0] w_sum_raw;
    logic        w_accept;
    logic [7:0]  w_byte;

    assign o_in_ready = !r_snap_vld || i_snap_take;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_byte     = i_in_beat.data_byte;
    assign o_snap_vld = r_snap_vld;
    assign o_snap     = r_snap;

    always_comb begin
        n_byte_index   = r_byte_index;
        n_sum          = r_sum;
        n_high_half    = r_high_half;
        n_ver_ihl      = r_ver_ihl;
        n_total_length = r_total_length;
        n_proto        = r_proto;
        n_src          = r_src;
        n_tcp_offset   = r_tcp_offset;
        w_sum_raw      = {1'b0, r_sum} + {2'b00, r_high_half, w_byte};

        if (r_byte_index < ipv4rx_pkg::HDR_BYTES) begin
            if (!r_byte_index[0]) begin
                n_high_half = w_byte;
            end else begin
                n_sum = {1'b0, w_sum_raw[15:0]} + {15'd0, w_sum_raw[17:16]};
            end
        end
        if (r_byte_index == ipv4rx_pkg::POS_VER_IHL) begin
            n_ver_ihl = w_byte;
        end
        if (r_byte_index == ipv4rx_pkg::POS_TLEN_HI) begin
            n_total_length = {w_byte, r_total_length[7:0]};
        end
        if (r_byte_index == ipv4rx_pkg::POS_TLEN_LO) begin
            n_total_length = {r_total_length[15:8], w_byte};
        end
        if (r_byte_index == ipv4rx_pkg::POS_PROTO) begin
            n_proto = w_byte;
        end
        if (r_byte_index >= ipv4rx_pkg::POS_SRC_FIRST &&
            r_byte_index <= ipv4rx_pkg::POS_SRC_LAST) begin
            n_src = {r_src[23:0], w_byte};
        end
        if (r_byte_index == ipv4rx_pkg::POS_TCP_OFF) begin
            n_tcp_offset = w_byte[7:4];
        end
        if (r_byte_index < ipv4rx_pkg::BYTE_CNT_MAX) begin
            n_byte_index = r_byte_index + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index   <= '0;
            r_sum          <= '0;
            r_high_half    <= '0;
            r_ver_ihl      <= '0;
            r_total_length <= '0;
            r_proto        <= '0;
            r_src          <= '0;
            r_tcp_offset   <= '0;
            r_snap_vld     <= 1'b0;
        end else begin
            if (w_accept && i_in_beat.last_byte) begin
                r_byte_index   <= '0;
                r_sum          <= '0;
                r_high_half    <= '0;
                r_ver_ihl      <= '0;
                r_total_length <= '0;
                r_proto        <= '0;
                r_src          <= '0;
                r_tcp_offset   <= '0;
                r_snap_vld     <= 1'b1;
            end else begin
                if (w_accept) begin
                    r_byte_index   <= n_byte_index;
                    r_sum          <= n_sum;
                    r_high_half    <= n_high_half;
                    r_ver_ihl      <= n_ver_ihl;
                    r_total_length <= n_total_length;
                    r_proto        <= n_proto;
                    r_src          <= n_src;
                    r_tcp_offset   <= n_tcp_offset;
                end
                if (i_snap_take) begin
                    r_snap_vld <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in_beat.last_byte) begin
            r_snap.byte_count     <= n_byte_index;
            r_snap.sum            <= n_sum;
            r_snap.ver_ihl        <= n_ver_ihl;
            r_snap.total_length   <= n_total_length;
            r_snap.payload_length <= n_total_length - ipv4rx_pkg::HDR_BYTES;
            r_snap.proto          <= n_proto;
            r_snap.src            <= n_src;
            r_snap.tcp_offset     <= n_tcp_offset;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_beat.last_byte) |=> (r_byte_index == '0 && r_sum == '0))
        else $error("Packet state not cleared after the last beat.");

    a_snap_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_snap_vld && !i_snap_take) |=> (r_snap_vld && $stable(r_snap)))
        else $error("Pending snapshot lost or overwritten.");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_in_beat.last_byte && r_byte_index == ipv4rx_pkg::BYTE_CNT_MAX)
        |=> (r_byte_index == ipv4rx_pkg::BYTE_CNT_MAX))
        else $error("Byte count wrapped past saturation.");

endmodule

>>> rtl/ipv4rx_verdict.sv
// ----------------------------------------------------------------------------
// IPv4 receive verdict stage
// Folds the header checksum, applies the drop checks and the protocol
// dispatch, and holds the result beat in the output register.
// ----------------------------------------------------------------------------
module ipv4rx_verdict (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_snap_vld,
    input  ipv4rx_pkg::t_hdr_snap i_snap,
    input  logic                  i_tcp_conn_open,
    input  logic                  i_out_ready,
    output logic                  o_snap_take,
    output logic                  o_out_valid,
    output ipv4rx_pkg::t_out_beat o_out_beat
);

    logic                  r_out_vld;
    ipv4rx_pkg::t_out_beat r_out_beat;
    ipv4rx_pkg::t_out_beat n_out_beat;
    logic [16:0]           w_fold1;
    logic [15:0]           w_fold2;
    logic [5:0]            w_thl;
    logic [15:0]           w_tpl;

    assign o_snap_take = !r_out_vld || i_out_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out_beat;

    always_comb begin
        w_fold1 = {1'b0, i_snap.sum[15:0]} + {16'd0, i_snap.sum[16]};
        w_fold2 = w_fold1[15:0] + {15'd0, w_fold1[16]};
        w_thl   = {i_snap.tcp_offset, 2'b00};
        w_tpl   = i_snap.payload_length - {10'd0, w_thl};

        n_out_beat = '0;
        n_out_beat.status = ipv4rx_pkg::ST_SHORT;
        priority if (i_snap.byte_count < ipv4rx_pkg::HDR_BYTES) begin
            n_out_beat.status = ipv4rx_pkg::ST_SHORT;
        end else if (i_snap.ver_ihl[7:4] != ipv4rx_pkg::IP_VERSION) begin
            n_out_beat.status = ipv4rx_pkg::ST_VERSION;
        end else if (i_snap.ver_ihl[3:0] != ipv4rx_pkg::IP_IHL) begin
            n_out_beat.status = ipv4rx_pkg::ST_IHL;
        end else if (i_snap.total_length < ipv4rx_pkg::HDR_BYTES ||
                     i_snap.total_length > i_snap.byte_count) begin
            n_out_beat.status = ipv4rx_pkg::ST_LENGTH;
        end else if (w_fold2 != ipv4rx_pkg::SUM_ONES) begin
            n_out_beat.status = ipv4rx_pkg::ST_CHECKSUM;
        end else begin
            n_out_beat.protocol_num   = i_snap.proto;
            n_out_beat.source_addr    = i_snap.src;
            n_out_beat.payload_length = i_snap.payload_length;
            priority if (i_snap.proto == ipv4rx_pkg::PROTO_ICMP) begin
                n_out_beat.status = ipv4rx_pkg::ST_ICMP;
            end else if (i_snap.proto == ipv4rx_pkg::PROTO_TCP) begin
                priority if (!i_tcp_conn_open) begin
                    n_out_beat.status = ipv4rx_pkg::ST_TCP_NO_CONN;
                end else if (i_snap.payload_length < ipv4rx_pkg::TCP_MIN_HDR ||
                             {10'd0, w_thl} < ipv4rx_pkg::TCP_MIN_HDR ||
                             {10'd0, w_thl} > i_snap.payload_length) begin
                    n_out_beat.status = ipv4rx_pkg::ST_TCP_BAD_HDR;
                end else begin
                    n_out_beat.status             = ipv4rx_pkg::ST_TCP;
                    n_out_beat.tcp_header_length  = w_thl;
                    n_out_beat.tcp_payload_length = w_tpl;
                end
            end else begin
                n_out_beat.status = ipv4rx_pkg::ST_OTHER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_snap_take) begin
            r_out_vld <= i_snap_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_snap_take && i_snap_vld) begin
            r_out_beat <= n_out_beat;
        end
    end

    a_tcp_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_beat.status != ipv4rx_pkg::ST_TCP) |->
        (r_out_beat.tcp_header_length == '0 && r_out_beat.tcp_payload_length == '0))
        else $error("TCP fields set on a non-delivered verdict.");

    a_drop_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out_beat.status == ipv4rx_pkg::ST_SHORT ||
                       r_out_beat.status == ipv4rx_pkg::ST_VERSION ||
                       r_out_beat.status == ipv4rx_pkg::ST_IHL ||
                       r_out_beat.status == ipv4rx_pkg::ST_LENGTH ||
                       r_out_beat.status == ipv4rx_pkg::ST_CHECKSUM)) |->
        (r_out_beat.protocol_num == '0 && r_out_beat.source_addr == '0 &&
         r_out_beat.payload_length == '0))
        else $error("Header fields set on a dropped packet.");

    a_tcp_len_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_beat.status == ipv4rx_pkg::ST_TCP) |->
        (r_out_beat.tcp_payload_length + {10'd0, r_out_beat.tcp_header_length}
         == r_out_beat.payload_length))
        else $error("TCP lengths do not add up to the payload length.");

endmodule

>>> rtl/ipv4_rx_header_check_top.sv
// ----------------------------------------------------------------------------
// IPv4 receive header check, top level
// Channel   Dir  Handshake                     Payload
// in        in   i_in_valid / o_in_ready       t_in_beat (data_byte, last_byte)
// out       out  o_out_valid / i_out_ready     t_out_beat (status and fields)
// config    in   psel/penable/pwrite, pready   paddr, pwdata, prdata
//
// One byte beat is taken per cycle while o_in_ready is high; the verdict for
// a packet is registered in the parse snapshot and then the output register.
// Reset is synchronous and clears the packet state and all valid flags.
// A stalled output holds its beat; bytes keep flowing until a second verdict
// is waiting behind it, and then o_in_ready drops.
// ----------------------------------------------------------------------------
module ipv4_rx_header_check_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  ipv4rx_pkg::t_in_beat                  i_in_beat,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output ipv4rx_pkg::t_out_beat                 o_out_beat,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ipv4rx_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [ipv4rx_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [ipv4rx_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                  pready
);

    logic                  r_tcp_conn_open;
    logic                  w_snap_vld;
    logic                  w_snap_take;
    logic                  w_reg_sel;
    logic                  w_cfg_wr;
    ipv4rx_pkg::t_hdr_snap w_snap;

    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[ipv4rx_pkg::CFG_ADDR_W-1] == ipv4rx_pkg::REG_TCP_CONN_OPEN);
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign prdata    = w_reg_sel ? {{(ipv4rx_pkg::CFG_DATA_W-1){1'b0}}, r_tcp_conn_open}
                                 : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcp_conn_open <= 1'b0;
        end else if (w_cfg_wr && w_reg_sel) begin
            r_tcp_conn_open <= pwdata[0];
        end
    end

    ipv4rx_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_beat   (i_in_beat),
        .o_in_ready  (o_in_ready),
        .i_snap_take (w_snap_take),
        .o_snap_vld  (w_snap_vld),
        .o_snap      (w_snap)
    );

    ipv4rx_verdict u_verdict (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_snap_vld      (w_snap_vld),
        .i_snap          (w_snap),
        .i_tcp_conn_open (r_tcp_conn_open),
        .i_out_ready     (i_out_ready),
        .o_snap_take     (w_snap_take),
        .o_out_valid     (o_out_valid),
        .o_out_beat      (o_out_beat)
    );

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && w_reg_sel) |=> (r_tcp_conn_open == $past(pwdata[0])))
        else $error("Connection-open register not updated by a write.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready && w_snap_vld))
        else $error("Input stalled without a full output path.");

    a_last_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_beat.last_byte && !o_out_valid)
        |=> ##1 o_out_valid)
        else $error("Verdict missing two cycles after the last beat.");

endmodule
